### design/pkcw_pkg.sv
package pkcw_pkg;

  localparam int unsigned PAGE_SLOTS  = 64;
  localparam int unsigned PHYS_BLOCKS = 1024;
  localparam int unsigned PAGE_IDX_W  = $clog2(PAGE_SLOTS);
  localparam int unsigned PHYS_W      = $clog2(PHYS_BLOCKS);
  localparam int unsigned POS_W       = 14;
  localparam int unsigned DIV_STEPS   = POS_W;
  localparam int unsigned ADDR_W      = 40;
  localparam int unsigned MID_DEPTH   = 4;
  localparam int unsigned MID_PTR_W   = $clog2(MID_DEPTH);
  localparam int unsigned OUT_DEPTH   = 8;
  localparam int unsigned OUT_PTR_W   = $clog2(OUT_DEPTH);

  // fp32 biased exponent limits for the fp16 range
  localparam logic [7:0]  EXP_ZERO_MAX = 8'd112;
  localparam logic [7:0]  EXP_INF_MIN  = 8'd143;
  localparam logic [14:0] HALF_INF     = 15'h7C00;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_STORE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_BLOCK_SIZE  = 3'd0,
    REG_KV_HEADS    = 3'd1,
    REG_HEAD_DIM    = 3'd2,
    REG_LAYER_COUNT = 3'd3,
    REG_PAGES_USED  = 3'd4,
    REG_CACHE_BASE  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    op_e                   op;
    logic [PAGE_IDX_W-1:0] page_index;
    logic [PHYS_W-1:0]     phys;
    logic [POS_W-1:0]      logical;
    logic [8:0]            tok;
    logic [6:0]            layer;
    logic                  kv;
    logic [5:0]            head;
    logic [7:0]            dim;
    logic [15:0]           half;
  } mid_item_t;

  typedef struct packed {
    mid_item_t        item;
    logic [POS_W-1:0] divd;
  } div_stage_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [15:0]       half;
    logic              error;
  } out_item_t;

  // One restoring division step: logical collects the quotient, tok the remainder.
  function automatic div_stage_t div_step(div_stage_t s, logic [8:0] bs);
    div_stage_t r;
    logic [9:0] part;
    r    = s;
    part = {s.item.tok, s.divd[POS_W-1]};
    if (part >= {1'b0, bs}) begin
      part = part - {1'b0, bs};
      r.item.logical = {s.item.logical[POS_W-2:0], 1'b1};
    end else begin
      r.item.logical = {s.item.logical[POS_W-2:0], 1'b0};
    end
    r.item.tok = part[8:0];
    r.divd     = {s.divd[POS_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

### design/pkcw_ram.sv
module pkcw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/pkcw_front.sv
module pkcw_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  in_vld_i,
  input  pkcw_pkg::div_stage_t  in_i,
  input  logic [8:0]            bsize_i,
  output logic                  out_vld_o,
  output pkcw_pkg::mid_item_t   out_o
);
  import pkcw_pkg::*;

  logic [DIV_STEPS:0] vld_q;
  div_stage_t         st_q [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[DIV_STEPS-1:0], in_vld_i};
    end
  end

  // advance the whole divider pipe together; hold it while the queue is full
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0] <= in_i;
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_q[k+1] <= div_step(st_q[k], bsize_i);
      end
    end
  end

  assign out_vld_o = vld_q[DIV_STEPS];
  assign out_o     = st_q[DIV_STEPS].item;

endmodule

### design/pkcw_mid_queue.sv
module pkcw_mid_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pkcw_pkg::mid_item_t data_i,
  output logic                room_o,
  input  logic                pop_i,
  output logic                vld_o,
  output pkcw_pkg::mid_item_t data_o
);
  import pkcw_pkg::*;

  mid_item_t            mem_q [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_q, rd_q;
  logic [MID_PTR_W:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (MID_PTR_W+1)'(push_i) - (MID_PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign room_o = (cnt_q != (MID_PTR_W+1)'(MID_DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign data_o = mem_q[rd_q];

endmodule

### design/pkcw_back.sv
module pkcw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mid_vld_i,
  input  pkcw_pkg::mid_item_t   mid_i,
  output logic                  mid_pop_o,
  input  logic [15:0]           tstride_i,
  input  logic [24:0]           plane_i,
  input  logic [33:0]           pblk_i,
  input  logic [8:0]            hdim_i,
  input  logic [6:0]            limit_i,
  input  logic [39:0]           base_i,
  input  logic                  pop,
  output logic                  empty,
  output pkcw_pkg::out_item_t   out_o
);
  import pkcw_pkg::*;

  // stage 1 (RAM data arrives)
  logic        b1_vld_q, b1_st_q, b1_err_q, b1_kv_q;
  logic [31:0] b1_layer_q;
  logic [24:0] b1_tok_q;
  logic [14:0] b1_head_q;
  logic [7:0]  b1_dim_q;
  logic [15:0] b1_half_q;
  logic [PHYS_W-1:0] ram_rdata;

  // stage 2
  logic        b2_vld_q, b2_st_q, b2_err_q;
  logic [43:0] b2_prod_q;
  logic [41:0] b2_part_q;
  logic [15:0] b2_half_q;

  // output queue
  out_item_t            oq_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owr_q, ord_q;
  logic [OUT_PTR_W:0]   ocnt_q;
  logic [OUT_PTR_W+1:0] pending;
  logic                 opush, opop, is_err;
  out_item_t            oitem;
  logic [43:0]          sum;

  assign pending   = (OUT_PTR_W+2)'(ocnt_q) + (OUT_PTR_W+2)'(b1_vld_q)
                   + (OUT_PTR_W+2)'(b2_vld_q);
  assign mid_pop_o = mid_vld_i && (pending < (OUT_PTR_W+2)'(OUT_DEPTH));
  assign is_err    = (mid_i.logical >= POS_W'(limit_i));

  pkcw_ram #(.Width(PHYS_W), .Depth(PAGE_SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (mid_pop_o && (mid_i.op == OP_LOAD)),
    .waddr_i (mid_i.page_index),
    .wdata_i (mid_i.phys),
    .raddr_i (mid_i.logical[PAGE_IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
    end else begin
      b1_vld_q <= mid_pop_o;
      b2_vld_q <= b1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_st_q    <= (mid_i.op == OP_STORE);
    b1_err_q   <= is_err;
    b1_kv_q    <= mid_i.kv;
    b1_layer_q <= 32'(mid_i.layer * plane_i);
    b1_tok_q   <= 25'(mid_i.tok * tstride_i);
    b1_head_q  <= 15'(mid_i.head * hdim_i);
    b1_dim_q   <= mid_i.dim;
    b1_half_q  <= mid_i.half;

    b2_st_q    <= b1_st_q;
    b2_err_q   <= b1_err_q;
    b2_prod_q  <= 44'(ram_rdata * pblk_i);
    b2_part_q  <= 42'(base_i) + {b1_layer_q, 1'b0} + (b1_kv_q ? 42'(plane_i) : 42'd0)
                + 42'(b1_tok_q) + 42'(b1_head_q) + 42'(b1_dim_q);
    b2_half_q  <= b1_half_q;
  end

  // drop address and value of a store that lies beyond the pages in use
  assign sum = b2_prod_q + 44'(b2_part_q);
  always_comb begin
    oitem.error   = b2_err_q;
    oitem.address = b2_err_q ? '0 : sum[ADDR_W-1:0];
    oitem.half    = b2_err_q ? '0 : b2_half_q;
  end

  assign opush = b2_vld_q && b2_st_q;
  assign opop  = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (opush) owr_q <= owr_q + 1'b1;
      if (opop)  ord_q <= ord_q + 1'b1;
      ocnt_q <= ocnt_q + (OUT_PTR_W+1)'(opush) - (OUT_PTR_W+1)'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) oq_q[owr_q] <= oitem;
  end

  assign empty = (ocnt_q == '0);
  assign out_o = oq_q[ord_q];

endmodule

### design/paged_kv_cache_writer_unit.sv
// Paged key/value cache writer. Load beats (operation 0) write one page table
// slot and give no result; store beats (operation 1) give one result: the
// 40-bit cache word address of the element and its fp16 encoding made by
// truncation (underflow to signed zero, overflow and NaN to signed infinity),
// or error set with zero address and value when the position falls beyond
// the pages in use. One beat is taken per cycle unless full is high, and one
// result leaves per cycle while pop is high and empty is low. The path is a
// 15-stage front (input register, then the restoring divider that splits the
// position by the block size, one quotient bit per stage), a 4-entry queue,
// and a back end that reads the page table RAM, forms the partial products
// and adds them into an 8-entry result queue. Page table entries never loaded
// since reset read as anything. Write configuration only while the block is
// idle; derived strides settle after the last write via chained registers.
module paged_kv_cache_writer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [39:0] cfg_data_i,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [5:0]  page_index_i,
  input  logic [9:0]  physical_block_i,
  input  logic [13:0] position_i,
  input  logic [6:0]  layer_i,
  input  logic        kv_select_i,
  input  logic [5:0]  head_i,
  input  logic [7:0]  dim_i,
  input  logic [31:0] value_bits_i,
  // result queue side
  input  logic        pop,
  output logic        empty,
  output logic [39:0] address_o,
  output logic [15:0] half_bits_o,
  output logic        error_o
);
  import pkcw_pkg::*;

  logic [8:0]  bsize_q, hdim_q;
  logic [6:0]  heads_q, pages_q;
  logic [7:0]  layers_q;
  logic [39:0] base_q;

  logic [8:0]  bsize_eff;
  logic [15:0] tstride_q;
  logic [24:0] plane_q;
  logic [33:0] pblk_q;
  logic [6:0]  limit;

  logic       room, front_vld, mid_vld, mid_pop, accept;
  div_stage_t entry;
  mid_item_t  front_item, mid_item;
  out_item_t  result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q  <= 9'd16;
      heads_q  <= 7'd8;
      hdim_q   <= 9'd128;
      layers_q <= 8'd32;
      pages_q  <= 7'd0;
      base_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BLOCK_SIZE:  bsize_q  <= cfg_data_i[8:0];
        REG_KV_HEADS:    heads_q  <= cfg_data_i[6:0];
        REG_HEAD_DIM:    hdim_q   <= cfg_data_i[8:0];
        REG_LAYER_COUNT: layers_q <= cfg_data_i[7:0];
        REG_PAGES_USED:  pages_q  <= cfg_data_i[6:0];
        REG_CACHE_BASE:  base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // block size of zero behaves as one
  assign bsize_eff = (bsize_q == '0) ? 9'd1 : bsize_q;
  assign limit     = (pages_q > 7'(PAGE_SLOTS)) ? 7'(PAGE_SLOTS) : pages_q;

  // derived strides: one multiply per register, each fed by the one before
  always_ff @(posedge clk_i) begin
    tstride_q <= 16'(heads_q * hdim_q);
    plane_q   <= 25'(bsize_eff * tstride_q);
    pblk_q    <= {33'(plane_q * layers_q), 1'b0};
  end

  // convert fp32 to fp16 by truncation on the way in
  function automatic logic [15:0] to_half(logic [31:0] b);
    logic [7:0] e;
    e = b[30:23];
    if (e <= EXP_ZERO_MAX) return {b[31], 15'd0};
    if (e >= EXP_INF_MIN)  return {b[31], HALF_INF};
    return {b[31], 5'(e - EXP_ZERO_MAX), b[22:13]};
  endfunction

  assign full   = !room;
  assign accept = push && !full;

  always_comb begin
    entry.item.op         = op_e'(operation_i);
    entry.item.page_index = page_index_i;
    entry.item.phys       = physical_block_i;
    entry.item.logical    = '0;
    entry.item.tok        = '0;
    entry.item.layer      = layer_i;
    entry.item.kv         = kv_select_i;
    entry.item.head       = head_i;
    entry.item.dim        = dim_i;
    entry.item.half       = to_half(value_bits_i);
    entry.divd            = position_i;
  end

  pkcw_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (room),
    .in_vld_i  (accept),
    .in_i      (entry),
    .bsize_i   (bsize_eff),
    .out_vld_o (front_vld),
    .out_o     (front_item)
  );

  pkcw_mid_queue u_mid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_vld && room),
    .data_i (front_item),
    .room_o (room),
    .pop_i  (mid_pop),
    .vld_o  (mid_vld),
    .data_o (mid_item)
  );

  pkcw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mid_vld_i (mid_vld),
    .mid_i     (mid_item),
    .mid_pop_o (mid_pop),
    .tstride_i (tstride_q),
    .plane_i   (plane_q),
    .pblk_i    (pblk_q),
    .hdim_i    (hdim_q),
    .limit_i   (limit),
    .base_i    (base_q),
    .pop       (pop),
    .empty     (empty),
    .out_o     (result)
  );

  assign address_o   = result.address;
  assign half_bits_o = result.half;
  assign error_o     = result.error;

endmodule

### bench/pkcw_checker.sv
module pkcw_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [39:0] cfg_data_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic        operation_i,
  input  logic [5:0]  page_index_i,
  input  logic [9:0]  physical_block_i,
  input  logic [13:0] position_i,
  input  logic [6:0]  layer_i,
  input  logic        kv_select_i,
  input  logic [5:0]  head_i,
  input  logic [7:0]  dim_i,
  input  logic [31:0] value_bits_i,
  input  logic        pop_i,
  input  logic        empty_i,
  input  logic [39:0] address_i,
  input  logic [15:0] half_bits_i,
  input  logic        error_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pkcw_pkg::*;

  logic [8:0]  block_size;
  logic [6:0]  kv_heads;
  logic [8:0]  head_dim;
  logic [7:0]  layer_count;
  logic [6:0]  pages_used;
  logic [39:0] cache_base;
  logic [9:0]  page_map [PAGE_SLOTS];

  out_item_t cache_writes [$];

  // truncating fp32 to fp16: underflow to signed zero, overflow/NaN to infinity
  function automatic logic [15:0] fp32_to_half(logic [31:0] bits);
    int e;
    e = int'(bits[30:23]) - 112;
    if (e <= 0) return {bits[31], 15'd0};
    if (e >= 31) return {bits[31], HALF_INF};
    return {bits[31], e[4:0], bits[22:13]};
  endfunction

  function automatic out_item_t store_word(logic [13:0] pos, logic [6:0] lay, logic kv,
                                           logic [5:0] hd, logic [7:0] dm, logic [31:0] vb);
    out_item_t r;
    logic [63:0] bs, logical, tok, lim, tstride, plane, addr;
    bs      = (block_size == 0) ? 64'd1 : 64'(block_size);
    logical = 64'(pos) / bs;
    tok     = 64'(pos) % bs;
    lim     = (pages_used < PAGE_SLOTS) ? 64'(pages_used) : 64'(PAGE_SLOTS);
    r       = '0;
    if (logical >= lim) begin
      r.error = 1'b1;
      return r;
    end
    tstride = 64'(kv_heads) * 64'(head_dim);
    plane   = bs * tstride;
    addr    = 64'(cache_base) + 64'(page_map[logical]) * (2 * plane * 64'(layer_count))
            + 64'(lay) * 2 * plane + 64'(kv) * plane + tok * tstride
            + 64'(hd) * 64'(head_dim) + 64'(dm);
    r.address = addr[39:0];
    r.half    = fp32_to_half(vb);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      block_size  <= 9'd16;
      kv_heads    <= 7'd8;
      head_dim    <= 9'd128;
      layer_count <= 8'd32;
      pages_used  <= 7'd0;
      cache_base  <= '0;
      cache_writes.delete();
      mismatches_o <= 0;
      results_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BLOCK_SIZE:  block_size  <= cfg_data_i[8:0];
          REG_KV_HEADS:    kv_heads    <= cfg_data_i[6:0];
          REG_HEAD_DIM:    head_dim    <= cfg_data_i[8:0];
          REG_LAYER_COUNT: layer_count <= cfg_data_i[7:0];
          REG_PAGES_USED:  pages_used  <= cfg_data_i[6:0];
          REG_CACHE_BASE:  cache_base  <= cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        if (op_e'(operation_i) == OP_LOAD)
          page_map[page_index_i] <= physical_block_i;
        else
          cache_writes.insert(cache_writes.size(),
                              store_word(position_i, layer_i, kv_select_i, head_i,
                                         dim_i, value_bits_i));
      end
      if (pop_i && !empty_i) begin
        results_o <= results_o + 1;
        if (cache_writes.size() == 0) begin
          $display("%0t: unexpected result addr %h half %h err %b", $time,
                   address_i, half_bits_i, error_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = cache_writes.pop_front();
          if (want.address !== address_i || want.half !== half_bits_i ||
              want.error !== error_i) begin
            $display("%0t: mismatch expected addr %h half %h err %b, got %h %h %b",
                     $time, want.address, want.half, want.error,
                     address_i, half_bits_i, error_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = cache_writes.size();

endmodule

### bench/tb_paged_kv_cache_writer_unit.sv
module tb_paged_kv_cache_writer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pkcw_pkg::*;

  // index past the last register; writes to it must change nothing
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int         PHASES    = 8;
  localparam int         PER_PHASE = 190;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [39:0] cfg_data_i = '0;
  logic        cfg_ready_o;
  logic        push = 1'b0;
  logic        full;
  logic        operation_i = 1'b0;
  logic [5:0]  page_index_i = '0;
  logic [9:0]  physical_block_i = '0;
  logic [13:0] position_i = '0;
  logic [6:0]  layer_i = '0;
  logic        kv_select_i = 1'b0;
  logic [5:0]  head_i = '0;
  logic [7:0]  dim_i = '0;
  logic [31:0] value_bits_i = '0;
  logic        pop = 1'b0;
  logic        empty;
  logic [39:0] address_o;
  logic [15:0] half_bits_o;
  logic        error_o;

  int mismatches, waiting, results;
  int tx_idle_pct, rx_stall_pct;
  int beats_sent;
  int cur_bs, cur_pages;

  always #2 clk_i = ~clk_i;

  paged_kv_cache_writer_unit u_dut (.*);

  pkcw_checker u_check (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .push_i(push), .full_i(full), .operation_i, .page_index_i, .physical_block_i,
    .position_i, .layer_i, .kv_select_i, .head_i, .dim_i, .value_bits_i,
    .pop_i(pop), .empty_i(empty), .address_i(address_o), .half_bits_i(half_bits_o),
    .error_i(error_o), .mismatches_o(mismatches), .pending_o(waiting), .results_o(results)
  );

  // result side: stall at the current rate, redrawn every cycle
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= rx_stall_pct);
  end

  // Drive one beat and hold it until it is taken. Push is only dropped for
  // sender idling, never in the step where the next beat goes up.
  task automatic send_beat(op_e op, logic [5:0] slot, logic [9:0] phys, logic [13:0] pos,
                           logic [6:0] lay, logic kv, logic [5:0] hd, logic [7:0] dm,
                           logic [31:0] vb);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    operation_i      <= op;
    page_index_i     <= slot;
    physical_block_i <= phys;
    position_i       <= pos;
    layer_i          <= lay;
    kv_select_i      <= kv;
    head_i           <= hd;
    dim_i            <= dm;
    value_bits_i     <= vb;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic load_slot(logic [5:0] slot, logic [9:0] phys);
    send_beat(OP_LOAD, slot, phys, 14'($urandom), 7'($urandom), 1'($urandom),
              6'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic store_elem(logic [13:0] pos, logic [31:0] vb);
    send_beat(OP_STORE, 6'($urandom), 10'($urandom), pos, 7'($urandom), 1'($urandom),
              6'($urandom), 8'($urandom), vb);
  endtask

  // Hold until every result is back, then let the pipe and the stride logic settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [39:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_setting(int bs, int heads, int hdim, int layers, int pages,
                               logic [39:0] base);
    drain();
    write_reg(REG_BLOCK_SIZE, 40'(bs));
    write_reg(REG_KV_HEADS, 40'(heads));
    write_reg(REG_HEAD_DIM, 40'(hdim));
    write_reg(REG_LAYER_COUNT, 40'(layers));
    write_reg(REG_PAGES_USED, 40'(pages));
    write_reg(REG_CACHE_BASE, base);
    write_reg(REG_SPARE, 40'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
    cur_bs    = (bs == 0) ? 1 : bs;
    cur_pages = (pages > PAGE_SLOTS) ? PAGE_SLOTS : pages;
    repeat (5) @(posedge clk_i);
  endtask

  // fp32 patterns biased towards the conversion edges
  function automatic logic [31:0] pick_value();
    logic [7:0] ex;
    case ($urandom_range(5))
      0: ex = 8'd112;
      1: ex = 8'd113;
      2: ex = 8'd142;
      3: ex = 8'd143;
      4: ex = ($urandom_range(1)) ? 8'd0 : 8'd255;
      default: return $urandom;
    endcase
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  // Mostly positions that hit a loaded page, the rest anywhere in range.
  function automatic logic [13:0] pick_position();
    int p;
    if (cur_pages > 0 && $urandom_range(9) < 8) begin
      p = $urandom_range(cur_pages - 1) * cur_bs + $urandom_range(cur_bs - 1);
      if (p < 16384) return 14'(p);
    end
    return 14'($urandom);
  endfunction

  initial begin
    int bs_l [PHASES]     = '{16, 1, 256, 0, 511, 7, 32, 100};
    int heads_l [PHASES]  = '{8, 1, 64, 127, 3, 13, 4, 2};
    int hdim_l [PHASES]   = '{128, 1, 256, 511, 5, 64, 16, 3};
    int layers_l [PHASES] = '{32, 1, 128, 255, 7, 9, 2, 4};
    int pages_l [PHASES]  = '{64, 64, 64, 127, 0, 20, 33, 64};
    logic [39:0] base_l [PHASES];

    base_l = '{40'd0, 40'd0, 40'hFF_FFFF_FFFF, 40'({$urandom, $urandom}), 40'h55_5555_5555,
               40'hAA_AAAA_AAAA, 40'({$urandom, $urandom}), 40'd0};
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    beats_sent   = 0;
    cur_bs       = 16;
    cur_pages    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // fill the whole page table first so no store ever reads an unwritten slot
    for (int s = 0; s < PAGE_SLOTS; s++) load_slot(6'(s), 10'($urandom));

    // directed: field extremes and conversion corner cases at reset-like sizes
    apply_setting(bs_l[0], heads_l[0], hdim_l[0], layers_l[0], pages_l[0], base_l[0]);
    load_slot(6'd0, 10'd0);
    load_slot(6'd63, 10'd1023);
    send_beat(OP_STORE, 6'd0, 10'd0, 14'd0, 7'd0, 1'b0, 6'd0, 8'd0, 32'h0000_0000);
    send_beat(OP_STORE, 6'h3F, 10'h3FF, 14'd1023, 7'd127, 1'b1, 6'd63, 8'd255,
              32'h8000_0000);
    store_elem(14'd16383, 32'h3F80_0000);
    store_elem(14'd1024, 32'h3F80_0000);
    store_elem(14'd5, 32'h7F80_0000);
    store_elem(14'd6, 32'hFF80_0000);
    store_elem(14'd7, 32'h7FC0_0001);
    store_elem(14'd8, 32'h387F_FFFF);
    store_elem(14'd9, 32'h3880_0000);
    store_elem(14'd10, 32'h477F_E000);
    store_elem(14'd11, 32'hC780_0000);
    store_elem(14'd12, 32'hFFFF_FFFF);
    store_elem(14'd13, 32'h0000_0001);

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(bs_l[ph], heads_l[ph], hdim_l[ph], layers_l[ph], pages_l[ph], base_l[ph]);
      for (int n = 0; n < PER_PHASE; n++) begin
        // cycle the idling pattern within each setting, with a clean stretch first
        case ((n * 4) / PER_PHASE)
          0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
          1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
          2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
          default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
        endcase
        if ($urandom_range(9) == 0)
          load_slot(6'($urandom), 10'($urandom));
        else
          store_elem(pick_position(), pick_value());
      end
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    drain();
    $display("Covered %0d input beats and %0d results over %0d register settings,",
             beats_sent, results, PHASES);
    $display("including zero and oversize block sizes, empty page tables and wrap.");
    if (mismatches == 0) begin
      $display("tb_paged_kv_cache_writer_unit passed");
    end else begin
      $display("tb_paged_kv_cache_writer_unit failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_paged_kv_cache_writer_unit failed");
    $finish;
  end

endmodule

### paged_kv_cache_writer_unit.f
design/pkcw_pkg.sv
design/pkcw_ram.sv
design/pkcw_front.sv
design/pkcw_mid_queue.sv
design/pkcw_back.sv
design/paged_kv_cache_writer_unit.sv
bench/pkcw_checker.sv
bench/tb_paged_kv_cache_writer_unit.sv
